// File: rtl/sbrpb_pkg.sv
// shared types, constants and codes for the block row pointer builder
// no dependencies; imported by every module of the block
package sbrpb_pkg;

	localparam int MAX_COL_BLOCKS = 1024;
	localparam int MAX_BLOCK_ROWS = 65536;

	// field widths
	localparam int COL_W = 17;
	localparam int DIM_W = 7;
	localparam int ROW_W = 16;
	localparam int CNT_W = 11;
	localparam int TOT_W = 27;
	localparam int TAG_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	// column block index and divider sizing
	localparam int COL_BLK_W = $clog2(MAX_COL_BLOCKS);
	localparam int DIV_CYC = (COL_BLK_W + 1) / 2;
	localparam int QUO_W = 2 * DIV_CYC;
	localparam int STEP_W = $clog2(DIV_CYC + 1);
	localparam int DIV_W = DIM_W + QUO_W;
	localparam int CMP_W = (COL_W > DIV_W) ? COL_W : DIV_W;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [TAG_W-1:0] TAG_EMPTY = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [TOT_W-1:0] TOT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_COLUMNS,
		CFG_COL_BLOCK_DIM,
		CFG_IN_BASE,
		CFG_OUT_BASE
	} cfg_idx_t;

	typedef struct packed {
		logic [COL_W-1:0] num_columns;
		logic [DIM_W-1:0] col_block_dim;
		logic             in_base;
		logic             out_base;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic                 has_blk;
		logic [COL_BLK_W-1:0] blk;
		logic                 end_row;
		logic                 end_mat;
	} qitem_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_CHECK,
		BK_EMIT
	} bk_state_t;

endpackage

// File: rtl/sparse_block_row_pointer_builder_core.sv
// top level of the block row pointer builder: configuration registers,
// front, queue and back; depends on sbrpb_pkg, sbrpb_front, sbrpb_queue, sbrpb_back
//
// Column indices of a sparse matrix's nonzeros come in one word at a time, grouped by
// block row; the word that ends a block row produces one report word with the count of
// distinct column blocks, the start and end row pointers (output base added) and the
// running total. The front takes a word, strips the input base, drops indices outside
// the matrix or beyond the tag store, and divides by the block width two quotient bits
// per cycle: a word without a nonzero, or one whose column is dropped, is accepted and
// then handed to the queue; a word that goes through the divider passes through accept,
// the divider state and the hand-off to the queue, which waits while the queue is full.
// A 4-deep queue lets the back run on its own: it takes each word from the queue, reads
// and updates the tag store, emits the report on a closing word, and holds a closing
// word while the report register is still full. After reset, after the matrix's final
// block row and when the block row number wraps, the back sweeps the 1024-entry tag
// store; in_ready is low during that sweep, configuration writes are taken as ever.
// Configuration must be written only while the block is idle; it is not enforced.
module sparse_block_row_pointer_builder_core import sbrpb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  has_entry,
	input  logic [COL_W-1:0]      column,
	input  logic                  end_of_block_row,
	input  logic                  end_of_matrix,
	// report words
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ROW_W-1:0]      block_row_number,
	output logic [CNT_W-1:0]      block_count,
	output logic [TOT_W-1:0]      row_pointer_start,
	output logic [TOT_W-1:0]      row_pointer_end,
	output logic [TOT_W-1:0]      total_blocks,
	output logic                  last
);

	cfg_t    cfg_q;
	logic    clearing;
	logic    push_valid;
	qitem_t  push_item;
	logic    q_full;
	logic    q_pop;
	qitem_t  q_head;
	logic    q_empty;

	// configuration registers, reset to 65536 columns and unit block width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_columns   <= COL_W'(65536);
			cfg_q.col_block_dim <= DIM_W'(1);
			cfg_q.in_base       <= 1'b0;
			cfg_q.out_base      <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NUM_COLUMNS:   cfg_q.num_columns   <= cfg_data[COL_W-1:0];
				CFG_COL_BLOCK_DIM: cfg_q.col_block_dim <= cfg_data[DIM_W-1:0];
				CFG_IN_BASE:       cfg_q.in_base       <= cfg_data[0];
				CFG_OUT_BASE:      cfg_q.out_base      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: classify and divide
	sbrpb_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.has_entry        (has_entry),
		.column           (column),
		.end_of_block_row (end_of_block_row),
		.end_of_matrix    (end_of_matrix),
		.clearing         (clearing),
		.push_valid       (push_valid),
		.push_item        (push_item),
		.q_full           (q_full)
	);

	// decoupling queue
	sbrpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// back: tag store, counters and report register
	sbrpb_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.out_base          (cfg_q.out_base),
		.head              (q_head),
		.q_empty           (q_empty),
		.q_pop             (q_pop),
		.clearing          (clearing),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.block_row_number  (block_row_number),
		.block_count       (block_count),
		.row_pointer_start (row_pointer_start),
		.row_pointer_end   (row_pointer_end),
		.total_blocks      (total_blocks),
		.last              (last)
	);

endmodule

// File: rtl/sbrpb_queue.sv
// short fifo of classified words between front and back
// depends on sbrpb_pkg
module sbrpb_queue import sbrpb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	output logic   full,
	input  logic   pop,
	output qitem_t head,
	output logic   empty
);

	qitem_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: rtl/sbrpb_front.sv
// front: accepts input words, strips the base, range checks and divides
// by the block width two quotient bits a cycle; depends on sbrpb_pkg
module sbrpb_front import sbrpb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             has_entry,
	input  logic [COL_W-1:0] column,
	input  logic             end_of_block_row,
	input  logic             end_of_matrix,
	input  logic             clearing,
	output logic             push_valid,
	output qitem_t           push_item,
	input  logic             q_full
);

	fr_state_t           state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic [CMP_W-1:0]    rem_q;
	logic [CMP_W-1:0]    dv_q;
	logic [QUO_W-1:0]    quo_q;
	logic                has_q;
	logic                end_row_q;
	logic                end_mat_q;

	logic                accept;
	logic                above_base;
	logic [COL_W-1:0]    col;
	logic [CMP_W-1:0]    limit;
	logic                ok;
	logic                t1, t2;
	logic [CMP_W-1:0]    r1, r2;
	logic [CMP_W-1:0]    dv_half;
	logic                last_step;

	assign in_ready = (state_q == FR_IDLE) && !clearing;
	assign accept   = in_valid && in_ready;

	// classification of the incoming word
	assign above_base = (column >= COL_W'(cfg.in_base));
	assign col        = column - COL_W'(cfg.in_base);
	assign limit      = CMP_W'(cfg.col_block_dim) << COL_BLK_W;
	assign ok = has_entry && above_base && (cfg.col_block_dim != '0)
		&& (col < cfg.num_columns) && (CMP_W'(col) < limit);

	// two restoring division steps
	assign dv_half = dv_q >> 1;
	assign t1      = (rem_q >= dv_q);
	assign r1      = t1 ? (rem_q - dv_q) : rem_q;
	assign t2      = (r1 >= dv_half);
	assign r2      = t2 ? (r1 - dv_half) : r1;

	assign last_step = (step_q == STEP_W'(DIV_CYC - 1));

	assign push_item.has_blk = has_q;
	assign push_item.blk     = quo_q[COL_BLK_W-1:0];
	assign push_item.end_row = end_row_q;
	assign push_item.end_mat = end_mat_q;

	always_comb begin
		state_d    = state_q;
		push_valid = 1'b0;
		case (state_q)
			FR_IDLE: begin
				if (accept) state_d = ok ? FR_DIV : FR_PUSH;
			end
			FR_DIV: begin
				if (last_step) state_d = FR_PUSH;
			end
			FR_PUSH: begin
				push_valid = 1'b1;
				if (!q_full) state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) step_q <= '0;
			else if (state_q == FR_DIV) step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q     <= CMP_W'(col);
			dv_q      <= CMP_W'(cfg.col_block_dim) << (QUO_W - 1);
			quo_q     <= '0;
			has_q     <= ok;
			end_row_q <= end_of_block_row;
			end_mat_q <= end_of_matrix;
		end else if (state_q == FR_DIV) begin
			rem_q <= r2;
			dv_q  <= dv_q >> 2;
			quo_q <= {quo_q[QUO_W-3:0], t1, t2};
		end
	end

endmodule

// File: rtl/sbrpb_back.sv
// back: tag store lookup and update, block row counters, report register
// and tag clearing sweep; depends on sbrpb_pkg
module sbrpb_back import sbrpb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             out_base,
	input  qitem_t           head,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             clearing,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ROW_W-1:0] block_row_number,
	output logic [CNT_W-1:0] block_count,
	output logic [TOT_W-1:0] row_pointer_start,
	output logic [TOT_W-1:0] row_pointer_end,
	output logic [TOT_W-1:0] total_blocks,
	output logic             last
);

	bk_state_t              state_q, state_d;
	logic [COL_BLK_W-1:0]   clr_q;
	qitem_t                 item_q;
	logic [ROW_W-1:0]       row_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TOT_W-1:0]       tot_q;
	logic                   out_valid_q;

	logic [TAG_W-1:0]       tag_mem [MAX_COL_BLOCKS];
	logic [TAG_W-1:0]       tag_rd_q;
	logic                   mem_we;
	logic [COL_BLK_W-1:0]   mem_addr;
	logic [TAG_W-1:0]       mem_wdata;

	logic                   cnt_inc;
	logic                   emit;
	logic [ROW_W:0]         row_nxt;
	logic                   row_wrap;
	logic [TOT_W:0]         after_sum;
	logic [TOT_W-1:0]       after;
	logic [TOT_W:0]         start_sum;
	logic [TOT_W:0]         end_sum;

	assign clearing  = (state_q == BK_CLEAR);
	assign out_valid = out_valid_q;

	assign row_nxt  = (ROW_W+1)'(row_q) + 1'b1;
	assign row_wrap = (row_nxt >= (ROW_W+1)'(MAX_BLOCK_ROWS));

	// saturating pointer arithmetic
	assign after_sum = (TOT_W+1)'(tot_q) + (TOT_W+1)'(cnt_q);
	assign after     = after_sum[TOT_W] ? TOT_MAX : after_sum[TOT_W-1:0];
	assign start_sum = (TOT_W+1)'(tot_q) + (TOT_W+1)'(out_base);
	assign end_sum   = (TOT_W+1)'(after) + (TOT_W+1)'(out_base);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = item_q.blk;
		mem_wdata = TAG_W'(row_q);
		cnt_inc   = 1'b0;
		emit      = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = TAG_EMPTY;
				if (clr_q == COL_BLK_W'(MAX_COL_BLOCKS - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (item_q.has_blk && (tag_rd_q != TAG_W'(row_q))) begin
					mem_we  = 1'b1;
					cnt_inc = 1'b1;
				end
				state_d = item_q.end_row ? BK_EMIT : BK_IDLE;
			end
			BK_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = (item_q.end_mat || row_wrap) ? BK_CLEAR : BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			tot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
			if (cnt_inc && (cnt_q != CNT_MAX)) cnt_q <= cnt_q + 1'b1;
			if (emit) begin
				cnt_q <= '0;
				if (item_q.end_mat) begin
					row_q <= '0;
					tot_q <= '0;
				end else begin
					row_q <= row_wrap ? '0 : row_nxt[ROW_W-1:0];
					tot_q <= after;
				end
			end
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= head;
		if (emit) begin
			block_row_number  <= row_q;
			block_count       <= cnt_q;
			row_pointer_start <= start_sum[TOT_W] ? TOT_MAX : start_sum[TOT_W-1:0];
			row_pointer_end   <= end_sum[TOT_W] ? TOT_MAX : end_sum[TOT_W-1:0];
			total_blocks      <= after;
			last              <= item_q.end_mat;
		end
	end

	// tag store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) tag_mem[mem_addr] <= mem_wdata;
		tag_rd_q <= tag_mem[head.blk];
	end

endmodule

// File: rtl/sbrpb_checker.sv
// port level checks of the block row pointer builder and their bind
// depends on sbrpb_pkg and sparse_block_row_pointer_builder_core
module sbrpb_checker import sbrpb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [ROW_W-1:0] block_row_number,
	input logic [CNT_W-1:0] block_count,
	input logic [TOT_W-1:0] row_pointer_start,
	input logic [TOT_W-1:0] row_pointer_end,
	input logic [TOT_W-1:0] total_blocks,
	input logic             last
);

	// a stalled report word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_blocks)
			&& $stable(block_count) && $stable(last))
		else $error("report word changed while stalled");

	// a pending input word is not withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input valid dropped before accept");

	// end pointer never below start pointer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_pointer_end >= row_pointer_start)
		else $error("row pointer end below start");

	// total includes this block row's count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total_blocks >= TOT_W'(block_count))
		else $error("total below block count");

	// after the matrix's last report the next one starts at block row zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid || block_row_number == '0)
		else $error("block row number not restarted after matrix end");

endmodule

bind sparse_block_row_pointer_builder_core sbrpb_checker u_sbrpb_checker (.*);
